[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TDPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define TDPT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/tdpt_pkg.sv]
// ---------------------------------------------------------------------------
// Trial division prime test package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package tdpt_pkg;

  // Default width of the tested value.
  localparam int unsigned VALUE_WIDTH_DEF = 31;

  // First candidate divisor.
  localparam int unsigned DIVISOR_START = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture a new item and set up the first trial
    logic div_step;      // one restoring division step
    logic next_d;        // advance to the next divisor and restart division
    logic finish;        // write the result register and the sticky flag
    logic result_prime;  // primality verdict written on finish
  } tdpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;    // the current division step is the last one
    logic below_two;   // the value is below two
    logic bound_fail;  // divisor exceeds the quotient, so d*d > n
    logic rem_zero;    // the divisor divides the value exactly
    logic out_free;    // the result register can take a new result
  } tdpt_status_t;

endpackage

[sv/tdpt_dp.sv]
// ---------------------------------------------------------------------------
// Trial division prime test datapath
// Holds the value and divisor, runs a one-bit-per-cycle restoring divider
// and owns the result register and the sticky prime flag.
// ---------------------------------------------------------------------------
module tdpt_dp #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tdpt_pkg::tdpt_cmd_t      cmd,
  output tdpt_pkg::tdpt_status_t   status,
  input  logic [VALUE_WIDTH-1:0]   number,
  input  logic                     run_start,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     is_prime,
  output logic                     any_prime
);
  import tdpt_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] n;
  logic                   start_flag;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH-1:0] r;
  logic [VALUE_WIDTH-1:0] q;
  logic [CW-1:0]          cnt;
  logic                   seen_prime;

  logic [VALUE_WIDTH:0]   r_shift;
  logic [VALUE_WIDTH:0]   r_diff;
  logic                   r_ge;
  logic                   any_next;

  // Restoring division: shift in the next dividend bit, subtract if it fits.
  assign r_shift = {r, q[VALUE_WIDTH-1]};
  assign r_ge    = (r_shift >= {1'b0, d});
  assign r_diff  = r_shift - {1'b0, d};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n          <= number;
      start_flag <= run_start;
      d          <= VALUE_WIDTH'(DIVISOR_START);
      r          <= '0;
      q          <= number;
      cnt        <= '0;
    end else if (cmd.next_d) begin
      d   <= d + VALUE_WIDTH'(1);
      r   <= '0;
      q   <= n;
      cnt <= '0;
    end else if (cmd.div_step) begin
      r   <= r_ge ? r_diff[VALUE_WIDTH-1:0] : r_shift[VALUE_WIDTH-1:0];
      q   <= {q[VALUE_WIDTH-2:0], r_ge};
      cnt <= cnt + CW'(1);
    end
  end

  assign any_next = cmd.result_prime | (seen_prime & ~start_flag);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      seen_prime   <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
      seen_prime   <= any_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      is_prime  <= cmd.result_prime;
      any_prime <= any_next;
    end
  end

  always_comb begin
    status.div_last   = (cnt == CW'(VALUE_WIDTH - 1));
    status.below_two  = (n[VALUE_WIDTH-1:1] == '0);
    status.bound_fail = (d > q);
    status.rem_zero   = (r == '0);
    status.out_free   = ~result_valid | ~result_stall;
  end

endmodule

[sv/tdpt_ctrl.sv]
// ---------------------------------------------------------------------------
// Trial division prime test controller
// Sequences item capture, the division steps for each divisor, the
// divisor checks and the hand-off of the result.
// ---------------------------------------------------------------------------
module tdpt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    busy,
  input  tdpt_pkg::tdpt_status_t  status,
  output tdpt_pkg::tdpt_cmd_t     cmd
);
  import tdpt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       done;

  // The test ends on a small value, on passing the square root bound,
  // or on an exact divisor.
  assign done = status.below_two | status.bound_fail | status.rem_zero;
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.result_prime = ~status.below_two & status.bound_fail;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (done) begin
          if (status.out_free) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.next_d = 1'b1;
          state_next = S_DIV;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/trial_division_prime_test.sv]
// ---------------------------------------------------------------------------
// Trial division prime test
// Tests one unsigned value per transaction for primality by trial division.
// The item channel carries number and run_start under item_valid and
// item_stall; the result channel carries is_prime and any_prime under
// result_valid and result_stall. Every item gives exactly one result.
// Candidate divisors run from two upward while d*d <= number; each divisor
// takes VALUE_WIDTH steps of the bit-serial restoring divider plus one
// check state, so an item that stops after k divisors runs k divisions
// before its result is written to the output register.
// Zero and one run one division and are then reported as not prime.
// any_prime is a sticky flag: run_start clears it ahead of its own item.
// Reset clears the controller, the result valid and the sticky flag.
// A finished result sits in an output register, so a new item is taken
// while the receiver stalls; the next finished result waits in the check
// state until the output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [VALUE_WIDTH-1:0] number,
  input  logic                   run_start,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   is_prime,
  output logic                   any_prime
);
  import tdpt_pkg::*;

  tdpt_cmd_t    cmd;
  tdpt_status_t status;
  logic         busy;

  // The controller takes an item only from its idle state.
  assign item_stall = busy;

  tdpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .busy       (busy),
    .status     (status),
    .cmd        (cmd)
  );

  tdpt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .number       (number),
    .run_start    (run_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_prime     (is_prime),
    .any_prime    (any_prime)
  );

  // A prime result always raises the sticky flag in the same transaction.
  `TDPT_ASSERT(a_prime_sets_any, result_valid && is_prime |-> any_prime, "prime without any_prime")
  // A result is never written over one that the receiver has not taken.
  `TDPT_ASSERT_NEVER(a_no_overwrite, cmd.finish && result_valid && result_stall, "result lost")
  // Values below two are never reported as prime.
  `TDPT_ASSERT(a_small_not_prime, cmd.finish && status.below_two |-> !cmd.result_prime, "small prime")
  // Finishing a test always presents a result on the next cycle.
  `TDPT_ASSERT(a_finish_valid, cmd.finish |=> result_valid, "finish without result")

endmodule

[tb/trial_division_prime_test_test.sv]
// ---------------------------------------------------------------------------
// Trial division prime test testbench
// Sends directed and random values through the item channel and checks every
// is_prime and any_prime result against a local primality predictor. Both
// channels idle and stall at random, with one calm stretch and one pause in
// which the sender waits for the block to drain.
// ---------------------------------------------------------------------------
module trial_division_prime_test_test;

  localparam int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF;

  // Generous cycle limit. It covers the slowest directed item and every
  // random item, so a correct run stays below the limit even with every
  // stall the receiver can add.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // Cycles to wait after the last result so a stray extra result shows up.
  localparam int unsigned DRAIN_CYCLES = 4 * (VALUE_WIDTH + 1);

  // Chance, in percent, that a side idles in a given cycle.
  localparam int unsigned IDLE_PERCENT = 23;

  // Number of random transactions.
  localparam int unsigned RANDOM_ITEMS = 100;

  // One expected result, together with the value that caused it so that a
  // mismatch report can say which transaction went wrong.
  typedef struct {
    logic [VALUE_WIDTH-1:0] number;
    logic                   is_prime;
    logic                   any_prime;
  } prime_verdict_t;

  // The scoreboard keeps its own copy of the sticky flag and a queue of
  // verdicts in the order the items were accepted. The block returns
  // exactly one result per item, in order, so the oldest entry always
  // belongs to the next result.
  class prime_scoreboard;
    prime_verdict_t verdicts[$];
    bit             seen_prime = 1'b0;
    int unsigned    errors     = 0;

    // Trial division with the bound d*d <= n written as d <= n / d, so the
    // divisor test never overflows. Values below two are never prime.
    function automatic bit prime_by_trial(logic [VALUE_WIDTH-1:0] n);
      longint unsigned value;
      longint unsigned divisor;
      value = n;
      if (value < tdpt_pkg::DIVISOR_START) return 1'b0;
      for (divisor = tdpt_pkg::DIVISOR_START; divisor <= value / divisor;
           divisor++) begin
        if (value % divisor == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic [VALUE_WIDTH-1:0] n, logic rs);
      prime_verdict_t v;
      if (rs) seen_prime = 1'b0;
      v.number    = n;
      v.is_prime  = prime_by_trial(n);
      if (v.is_prime) seen_prime = 1'b1;
      v.any_prime = seen_prime;
      verdicts.push_back(v);
    endfunction

    function void check_result(logic got_prime, logic got_any);
      prime_verdict_t v;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result is_prime=%0b any_prime=%0b", $time,
                 got_prime, got_any);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (got_prime !== v.is_prime) begin
        $display("%0t: is_prime for %0d: expected %0b, actual %0b", $time,
                 v.number, v.is_prime, got_prime);
        errors++;
      end
      if (got_any !== v.any_prime) begin
        $display("%0t: any_prime for %0d: expected %0b, actual %0b", $time,
                 v.number, v.any_prime, got_any);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction
  endclass

  // Every input starts at a known value; reset is held from time zero.
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  logic [VALUE_WIDTH-1:0] number       = '0;
  logic                   run_start    = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   is_prime;
  logic                   any_prime;

  // While calm is set neither side idles, which gives one long stretch of
  // back-to-back traffic.
  bit              calm = 1'b0;
  int unsigned     cycles = 0;
  prime_scoreboard sb = new;

  trial_division_prime_test #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .number       (number),
    .run_start    (run_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_prime     (is_prime),
    .any_prime    (any_prime)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side. Outputs are read just after the edge, before any register
  // in the block updates, so the values seen are the ones the edge sampled.
  // The stall for the next cycle is chosen in the same step.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) sb.check_result(is_prime, any_prime);
      result_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Sends one transaction. Idle cycles, if any, come before valid rises.
  // After acceptance valid stays high, so the next call either changes the
  // payload directly or lowers valid; each step gets a single assignment.
  task automatic send_item(input logic [VALUE_WIDTH-1:0] n, input logic rs);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    number     <= n;
    run_start  <= rs;
    do @(posedge clk); while (item_stall);
    sb.note_item(n, rs);
  endtask

  // Lowers valid and waits until every expected result has come back. The
  // queue is polled on the falling edge so the check at the rising edge has
  // always finished first.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [VALUE_WIDTH-1:0] n;
    logic                   rs;
    int unsigned            sel;
    int unsigned            factor;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Zero and one must never be prime; two and three have
    // no divisor to try and so are prime. Squares of primes stop only at
    // the last divisor the bound allows. A few large values cover the top
    // of the range without the cost of a full 31-bit prime search.
    send_item(0, 1'b1);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(4, 1'b1);            // run start clears the flag ahead of a composite
    send_item(5, 1'b0);
    send_item(9, 1'b1);
    send_item(25, 1'b0);
    send_item(49, 1'b0);
    send_item(121, 1'b0);
    send_item(63001, 1'b1);        // square of 251
    send_item(65521, 1'b0);        // largest 16-bit prime
    send_item(1022117, 1'b1);      // product of 1009 and 1013
    send_item(1048573, 1'b0);      // prime just below 2^20
    send_item(31'h7FFF_FFFE, 1'b1);
    send_item(31'h7FFF_FFFD, 1'b0);
    send_item(31'h4000_0000, 1'b0);
    send_item(31'h5555_5555, 1'b1);
    send_item(31'h2AAA_AAAA, 1'b0);
    send_item(1, 1'b1);            // run start followed by a non-prime

    // Random part. Most values are small so that primes, which take the
    // longest, stay cheap. Full-width values are rounded down to a multiple
    // of a small prime so they finish early while still toggling every bit.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 55 && i < 80);
      sel  = $urandom_range(99);
      if (sel < 55) begin
        n = VALUE_WIDTH'($urandom_range(1023));
      end else if (sel < 80) begin
        n = VALUE_WIDTH'($urandom_range(65535));
      end else begin
        n = VALUE_WIDTH'($urandom);
        case ($urandom_range(3))
          0: factor = 2;
          1: factor = 3;
          2: factor = 5;
          default: factor = 7;
        endcase
        n = n - VALUE_WIDTH'(n % factor);
      end
      rs = ($urandom_range(99) < 15);
      send_item(n, rs);
      // Once in the middle the sender holds off until the block is empty.
      if (i == 40) drain_results();
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
